// File: rtl/core/prgp_pkg.sv
// Package for the point range to gray pixel block.
// Holds field widths, register indexes, iteration counts and the unit status struct.
// No dependencies.
`timescale 1ns / 1ps

package prgp_pkg;

  localparam int COORD_W = 16;
  localparam int SQ_W    = 32;   // sum of three squares stays below 2**32
  localparam int RANGE_W = 16;
  localparam int GRAY_W  = 8;
  localparam int POS_W   = 10;
  localparam int CFG_W   = 16;
  localparam int IW_W    = 11;
  localparam int DIM_W   = 13;   // holds any width or height limit up to 4096
  localparam int ADDR_W  = 2;

  localparam int SQ_STEPS   = 16;
  localparam int ROOT_STEPS = 16;
  localparam int DIV_STEPS  = 8;

  localparam logic [ADDR_W-1:0] REG_RANGE_MIN   = 2'd0;
  localparam logic [ADDR_W-1:0] REG_RANGE_MAX   = 2'd1;
  localparam logic [ADDR_W-1:0] REG_IMAGE_WIDTH = 2'd2;

  localparam logic [GRAY_W-1:0] GRAY_BLACK = 8'd0;
  localparam logic [GRAY_W-1:0] GRAY_WHITE = 8'd255;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

// File: rtl/core/point_range_to_gray_pixel.sv
// Point range to gray pixel: range = floor(sqrt(x^2+y^2+z^2)), mapped to 8-bit gray.
// One word at a time: squaring, root (load, 16 steps, capture), mapping, a division when
// the range falls strictly between the limits, then the output register. The next word is
// taken only once the result is in the output register, and that waits while the register
// stays full. Synchronous active-low reset clears the pixel counters to zero and loads
// range_min_mm 1150, range_max_mm 1600, image_width 640.
`timescale 1ns / 1ps

module point_range_to_gray_pixel #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,    // x_mm[15:0], y_mm[31:16], z_mm[47:32]
  input  logic        in_tuser,    // frame_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,   // gray[7:0], pixel_row[17:8], pixel_column[27:18],
                                   // range_mm[43:28], zero[47:44]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [prgp_pkg::ADDR_W-1:0] cfg_addr,
  input  logic [prgp_pkg::CFG_W-1:0]  cfg_data
);

  localparam int CW = prgp_pkg::CFG_W;
  localparam int PW = prgp_pkg::POS_W;
  localparam int DW = prgp_pkg::DIM_W;

  typedef enum logic [2:0] {
    S_IDLE, S_SQ, S_ROOT, S_MAP, S_DIV, S_DONE
  } state_t;

  state_t state_r;

  logic [CW-1:0]                 range_min_r;
  logic [CW-1:0]                 range_max_r;
  logic [prgp_pkg::IW_W-1:0]     image_width_r;
  logic [PW-1:0]                 col_r;
  logic [PW-1:0]                 row_r;
  logic [PW-1:0]                 pos_col_r;
  logic [PW-1:0]                 pos_row_r;
  logic [prgp_pkg::RANGE_W-1:0]  range_r;
  logic [prgp_pkg::GRAY_W-1:0]   gray_r;
  logic                          out_valid_r;
  logic [47:0]                   out_data_r;

  logic                          in_fire;
  logic                          sq_start;
  logic                          rt_start;
  logic                          dv_start;
  prgp_pkg::unit_stat_t          sq_stat;
  prgp_pkg::unit_stat_t          rt_stat;
  prgp_pkg::unit_stat_t          dv_stat;
  logic [prgp_pkg::SQ_W-1:0]     sq_sum;
  logic [prgp_pkg::RANGE_W-1:0]  rt_root;
  logic [prgp_pkg::GRAY_W-1:0]   dv_q;

  logic [PW-1:0]                 cur_col;
  logic [PW-1:0]                 cur_row;
  logic [DW-1:0]                 width_eff;
  logic [PW-1:0]                 col_nxt;
  logic [PW-1:0]                 row_nxt;
  logic [CW-1:0]                 span;
  logic [CW-1:0]                 above;
  logic [CW+prgp_pkg::GRAY_W-1:0] scaled;
  logic                          is_black;
  logic                          is_white;
  logic                          out_free;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_tready;

  assign sq_start = in_fire;
  assign rt_start = (state_r == S_SQ) && sq_stat.done;
  assign dv_start = (state_r == S_MAP) && !is_black && !is_white;

  // pixel position: frame start clears before placing; width is clamped to [1, MAX_WIDTH]
  always_comb begin
    cur_col = in_tuser ? '0 : col_r;
    cur_row = in_tuser ? '0 : row_r;
    if (image_width_r == '0) begin
      width_eff = DW'(1);
    end else if (DW'(image_width_r) > DW'(MAX_WIDTH)) begin
      width_eff = DW'(MAX_WIDTH);
    end else begin
      width_eff = DW'(image_width_r);
    end
    if (DW'(cur_col) + DW'(1) >= width_eff) begin
      col_nxt = '0;
      if (DW'(cur_row) + DW'(1) >= DW'(MAX_HEIGHT)) begin
        row_nxt = '0;
      end else begin
        row_nxt = cur_row + 1'b1;
      end
    end else begin
      col_nxt = cur_col + 1'b1;
      row_nxt = cur_row;
    end
  end

  // gray mapping: clamp at the limits, else 255*(R-min)/(max-min)
  always_comb begin
    span     = range_max_r - range_min_r;
    above    = range_r - range_min_r;
    scaled   = {above, 8'd0} - (CW + prgp_pkg::GRAY_W)'(above);
    is_black = (range_r <= range_min_r);
    is_white = !is_black && ((range_max_r <= range_min_r) || (range_r >= range_max_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_min_r   <= CW'(1150);
      range_max_r   <= CW'(1600);
      image_width_r <= prgp_pkg::IW_W'(640);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_addr)
        prgp_pkg::REG_RANGE_MIN:   range_min_r   <= cfg_data;
        prgp_pkg::REG_RANGE_MAX:   range_max_r   <= cfg_data;
        prgp_pkg::REG_IMAGE_WIDTH: image_width_r <= cfg_data[prgp_pkg::IW_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      col_r       <= '0;
      row_r       <= '0;
    end else begin
      // drop the word once taken; S_DONE reloads it below
      if (out_tready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            col_r   <= col_nxt;
            row_r   <= row_nxt;
            state_r <= S_SQ;
          end
        end
        S_SQ: begin
          if (sq_stat.done) begin
            state_r <= S_ROOT;
          end
        end
        S_ROOT: begin
          if (rt_stat.done) begin
            state_r <= S_MAP;
          end
        end
        S_MAP: begin
          state_r <= dv_start ? S_DIV : S_DONE;
        end
        S_DIV: begin
          if (dv_stat.done) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          // hold until the output register is free
          if (out_free) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      pos_col_r <= cur_col;
      pos_row_r <= cur_row;
    end
    if (state_r == S_ROOT && rt_stat.done) begin
      range_r <= rt_root;
    end
    if (state_r == S_MAP) begin
      gray_r <= is_black ? prgp_pkg::GRAY_BLACK : prgp_pkg::GRAY_WHITE;
    end
    if (state_r == S_DIV && dv_stat.done) begin
      gray_r <= dv_q;
    end
    if (state_r == S_DONE && out_free) begin
      out_data_r <= {4'd0, range_r, pos_col_r, pos_row_r, gray_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  prgp_sq u_sq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .x_mm  (in_tdata[15:0]),
    .y_mm  (in_tdata[31:16]),
    .z_mm  (in_tdata[47:32]),
    .stat  (sq_stat),
    .sum   (sq_sum)
  );

  prgp_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rt_start),
    .radicand (sq_sum),
    .stat     (rt_stat),
    .root     (rt_root)
  );

  prgp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (dv_start),
    .dividend (scaled),
    .divisor  (span),
    .stat     (dv_stat),
    .quotient (dv_q)
  );

  a_idle_units: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !sq_stat.busy && !rt_stat.busy && !dv_stat.busy)
    else $error("unit busy while taking a new word");

  a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_tready)
    else $error("second word taken while one is in flight");

  a_sq_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    sq_stat.done |-> state_r == S_SQ)
    else $error("squarer finished outside its phase");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == S_DONE))
    else $error("result shown without finishing");

endmodule

// File: rtl/core/prgp_sq.sv
// Sum of squares of three signed coordinates, one multiplier bit per cycle per lane.
// Depends on prgp_pkg.
`timescale 1ns / 1ps

module prgp_sq (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [prgp_pkg::COORD_W-1:0] x_mm,
  input  logic signed [prgp_pkg::COORD_W-1:0] y_mm,
  input  logic signed [prgp_pkg::COORD_W-1:0] z_mm,
  output prgp_pkg::unit_stat_t              stat,
  output logic [prgp_pkg::SQ_W-1:0]         sum
);

  localparam int CntW = $clog2(prgp_pkg::SQ_STEPS);

  logic [prgp_pkg::COORD_W-1:0] a_r [3];
  logic [prgp_pkg::COORD_W-1:0] m_r [3];
  logic [prgp_pkg::SQ_W-1:0]    acc_r [3];
  logic [prgp_pkg::COORD_W-1:0] mag [3];
  logic [CntW-1:0]              cnt_r;
  logic                         busy_r;
  logic                         add_r;
  logic                         done_r;
  logic [prgp_pkg::SQ_W-1:0]    sum_r;

  always_comb begin
    mag[0] = x_mm[prgp_pkg::COORD_W-1] ? prgp_pkg::COORD_W'(-x_mm) : x_mm;
    mag[1] = y_mm[prgp_pkg::COORD_W-1] ? prgp_pkg::COORD_W'(-y_mm) : y_mm;
    mag[2] = z_mm[prgp_pkg::COORD_W-1] ? prgp_pkg::COORD_W'(-z_mm) : z_mm;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      add_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= add_r && !start;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (add_r) begin
        add_r  <= 1'b0;
        busy_r <= 1'b0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CntW'(prgp_pkg::SQ_STEPS - 1)) begin
          add_r <= 1'b1;
        end
      end
    end
  end

  // MSB-first shift-add: double the partial product, add the magnitude on a one bit
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (start) begin
        a_r[i]   <= mag[i];
        m_r[i]   <= mag[i];
        acc_r[i] <= '0;
      end else if (busy_r && !add_r) begin
        acc_r[i] <= (acc_r[i] << 1) +
                    (m_r[i][prgp_pkg::COORD_W-1] ? prgp_pkg::SQ_W'(a_r[i]) : '0);
        m_r[i]   <= m_r[i] << 1;
      end
    end
    if (add_r) begin
      sum_r <= acc_r[0] + acc_r[1] + acc_r[2];
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign sum       = sum_r;

endmodule

// File: rtl/core/prgp_isqrt.sv
// Floored integer square root, one root bit per cycle (two radicand bits shifted in).
// Depends on prgp_pkg.
`timescale 1ns / 1ps

module prgp_isqrt (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [prgp_pkg::SQ_W-1:0]      radicand,
  output prgp_pkg::unit_stat_t           stat,
  output logic [prgp_pkg::RANGE_W-1:0]   root
);

  localparam int CntW = $clog2(prgp_pkg::ROOT_STEPS);
  localparam int RemW = prgp_pkg::RANGE_W + 2;

  logic [prgp_pkg::SQ_W-1:0]    n_r;
  logic [RemW-1:0]              rem_r;
  logic [prgp_pkg::RANGE_W-1:0] root_r;
  logic [CntW-1:0]              cnt_r;
  logic                         busy_r;
  logic                         done_r;
  logic [RemW-1:0]              rem_sh;
  logic [RemW-1:0]              trial;
  logic                         fits;

  always_comb begin
    rem_sh = {rem_r[RemW-3:0], n_r[prgp_pkg::SQ_W-1 -: 2]};
    trial  = {root_r, 2'b01};
    fits   = (rem_sh >= trial);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= !start && busy_r && (cnt_r == CntW'(prgp_pkg::ROOT_STEPS - 1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CntW'(prgp_pkg::ROOT_STEPS - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n_r    <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      n_r    <= n_r << 2;
      rem_r  <= fits ? rem_sh - trial : rem_sh;
      root_r <= {root_r[prgp_pkg::RANGE_W-2:0], fits};
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign root      = root_r;

endmodule

// File: rtl/core/prgp_div.sv
// Restoring divider for the gray scale: 24-bit dividend, 16-bit divisor, 8-bit quotient,
// one quotient bit per cycle. Depends on prgp_pkg.
`timescale 1ns / 1ps

module prgp_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [prgp_pkg::CFG_W+prgp_pkg::GRAY_W-1:0] dividend,
  input  logic [prgp_pkg::CFG_W-1:0]     divisor,
  output prgp_pkg::unit_stat_t           stat,
  output logic [prgp_pkg::GRAY_W-1:0]    quotient
);

  localparam int CntW = $clog2(prgp_pkg::DIV_STEPS);
  localparam int DW   = prgp_pkg::CFG_W;
  localparam int QW   = prgp_pkg::GRAY_W;

  logic [DW-1:0]   rem_r;
  logic [DW-1:0]   den_r;
  logic [QW-1:0]   q_r;      // low dividend bits shift out as quotient bits shift in
  logic [CntW-1:0] cnt_r;
  logic            busy_r;
  logic            done_r;
  logic [DW:0]     t;
  logic            fits;

  always_comb begin
    t    = {rem_r, q_r[QW-1]};
    fits = (t >= {1'b0, den_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= !start && busy_r && (cnt_r == CntW'(prgp_pkg::DIV_STEPS - 1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CntW'(prgp_pkg::DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // upper dividend bits are below the divisor since the quotient fits in 8 bits
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend[DW+QW-1:QW];
      q_r   <= dividend[QW-1:0];
      den_r <= divisor;
    end else if (busy_r) begin
      rem_r <= fits ? DW'(t - {1'b0, den_r}) : t[DW-1:0];
      q_r   <= {q_r[QW-2:0], fits};
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = q_r;

endmodule
